@@ rtl/core/tevm_pkg.sv @@
// ----------------------------------------------------------------------------
// tevm_pkg: shared constants and helpers for the ternary VM core
// Memory geometry, phase/event/command codes, instruction characters,
// decode and re-encryption tables, and constant-divide helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tevm_pkg;

	// Memory geometry
	localparam int unsigned MemWords  = 59049;
	localparam int unsigned MemLast   = 59048;
	localparam int unsigned WordW     = 16;
	localparam int unsigned AddrW     = 16;
	localparam int unsigned RotWeight = 19683;
	localparam int unsigned TableLen  = 94;
	localparam int unsigned CharLow   = 33;
	localparam int unsigned CharHigh  = 126;
	localparam int unsigned Radix     = 9;
	localparam int unsigned CrazyDigits = 5;

	// Reciprocals for constant division (exact over the operand ranges used)
	localparam int unsigned RecipNine  = 58255;  // floor(x*r >> 19) == x / 9
	localparam int unsigned RecipThree = 43691;  // floor(x*r >> 17) == x / 3
	localparam int unsigned RecipTable = 89241;  // floor(x*r >> 23) == x / 94

	// Machine phases
	localparam logic [1:0] PhLoading = 2'd0;
	localparam logic [1:0] PhRunning = 2'd1;
	localparam logic [1:0] PhHalted  = 2'd2;
	localparam logic [1:0] PhFailed  = 2'd3;

	// Commands
	localparam logic [1:0] CmdLoad   = 2'd0;
	localparam logic [1:0] CmdFinish = 2'd1;
	localparam logic [1:0] CmdStep   = 2'd2;

	// Result events
	localparam logic [2:0] EvNone  = 3'd0;
	localparam logic [2:0] EvOut   = 3'd1;
	localparam logic [2:0] EvIn    = 3'd2;
	localparam logic [2:0] EvHalt  = 3'd3;
	localparam logic [2:0] EvLong  = 3'd4;
	localparam logic [2:0] EvShort = 3'd5;

	// Decoded instruction characters
	localparam logic [7:0] InsJump   = "i";
	localparam logic [7:0] InsMoveD  = "j";
	localparam logic [7:0] InsRotate = "*";
	localparam logic [7:0] InsCrazy  = "p";
	localparam logic [7:0] InsOut    = "<";
	localparam logic [7:0] InsIn     = "/";
	localparam logic [7:0] InsHalt   = "v";

	// Rotation tables, first character in the top byte
	localparam logic [8*TableLen-1:0] DecodeTab = {
		"+b(29e*j1VMEKLyC})8&m#~W>qxdRp0wkrUo[D7,XTcA\"lI",
		".v%{gJh4G\\-=O@5`_3i<?Z';FNQuY]szf$!BS/|t:Pn6^Ha"
	};
	localparam logic [8*TableLen-1:0] EncryptTab = {
		"5z]&gqtyfr$(we4{WP)H-Zn,[%\\3dL+Q;>U!pJS72FhOA1C",
		"B6v^=I_0/8|jsb9m<.TVac`uY*MK'X~xDl}REokN:#?G\"i@"
	};

	// Digit weights and crazy-op digit table, indexed [memory digit * 9 + acc digit]
	localparam logic [12:0] Pow9 [CrazyDigits] = '{1, 9, 81, 729, 6561};
	localparam logic [3:0] CrazyTab [81] = '{
		4,3,3,1,0,0,1,0,0, 4,3,5,1,0,2,1,0,2, 5,5,4,2,2,1,2,2,1,
		4,3,3,1,0,0,7,6,6, 4,3,5,1,0,2,7,6,8, 5,5,4,2,2,1,8,8,7,
		7,6,6,7,6,6,4,3,3, 7,6,8,7,6,8,4,3,5, 8,8,7,8,8,7,5,5,4
	};

	function automatic logic is_printable(input logic [WordW-1:0] v);
		return (v >= WordW'(CharLow)) && (v <= WordW'(CharHigh));
	endfunction

	function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] v);
		return (v >= AddrW'(MemLast)) ? '0 : AddrW'(v + AddrW'(1));
	endfunction

	function automatic logic [WordW-1:0] div9(input logic [WordW-1:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RecipNine);
		return WordW'(p[31:19]);
	endfunction

	// Ternary rotate right by one trit: x / 3 + (x % 3) * 3^9
	function automatic logic [WordW-1:0] rotate_word(input logic [WordW-1:0] x);
		logic [31:0]      p;
		logic [WordW-1:0] q;
		logic [1:0]       r;
		p = 32'(x) * 32'(RecipThree);
		q = WordW'(p[31:17]);
		r = 2'(x - WordW'(q * WordW'(3)));
		case (r)
			2'd1:    return WordW'(q + WordW'(RotWeight));
			2'd2:    return WordW'(q + WordW'(2 * RotWeight));
			default: return q;
		endcase
	endfunction

	function automatic logic [7:0] decode_char(input logic [6:0] idx);
		return DecodeTab[(TableLen - 1 - int'(idx)) * 8 +: 8];
	endfunction

	function automatic logic [7:0] encrypt_char(input logic [6:0] idx);
		return EncryptTab[(TableLen - 1 - int'(idx)) * 8 +: 8];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ternary_esoteric_vm_core.sv @@
// ----------------------------------------------------------------------------
// ternary_esoteric_vm_core: self-modifying ternary machine, 59049-word memory
// A load, finish-rejected or idle item goes to RESP; a step runs DEC, OP,
// EXE, ENC, WB, RESP (DEC to RESP for an unprintable code word, EXE to RESP
// for a halt), with CRZ for a crazy-op (five base-9 digits, one per cycle);
// a finish runs FILL, five digits per filled word. One item at a time, bound
// by the single memory port pair; a held result delays the next response.
// Reset clears A, C, D, the load count and the phase; memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_esoteric_vm_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] data_char,
	input  wire logic       input_eof,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      event_res,
	output logic [7:0]      out_char,
	output logic [15:0]     accumulator,
	output logic [15:0]     code_pointer,
	output logic [15:0]     data_pointer
);

	import tevm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RESP = 4'd1;
	localparam logic [3:0] ST_FILL = 4'd2;
	localparam logic [3:0] ST_DEC  = 4'd3;
	localparam logic [3:0] ST_OP   = 4'd4;
	localparam logic [3:0] ST_EXE  = 4'd5;
	localparam logic [3:0] ST_CRZ  = 4'd6;
	localparam logic [3:0] ST_ENC  = 4'd7;
	localparam logic [3:0] ST_WB   = 4'd8;

	// Control and architectural state
	logic [3:0]       state_q;
	logic [1:0]       phase_q;
	logic [WordW-1:0] acc_q;
	logic [AddrW-1:0] code_q;
	logic [AddrW-1:0] data_q;
	logic [AddrW-1:0] load_count_q;
	logic             out_valid_q;

	// Datapath registers
	logic [WordW-1:0] w1_q, w2_q;
	logic [WordW-1:0] md_q;
	logic [16:0]      sum_q;
	logic [33:0]      prod_q;
	logic [7:0]       ins_q;
	logic [7:0]       ch_q;
	logic             eof_q;
	logic [2:0]       ev_q;
	logic [7:0]       oc_q;
	logic [WordW-1:0] ca_q, cm_q, cr_q;
	logic [2:0]       ck_q;
	logic             rd_oob_q;
	logic [2:0]       out_ev_q;
	logic [7:0]       out_oc_q;
	logic [WordW-1:0] out_acc_q, out_code_q, out_data_q;

	// Memory port
	logic             mem_we, ram_we;
	logic [AddrW-1:0] mem_waddr, mem_raddr;
	logic [WordW-1:0] mem_wdata, ram_rdata, rd_word;

	logic accept, slot_free, load_ok;
	logic [16:0] dec_sum;
	logic [10:0] q94;
	logic [6:0]  dec_idx;
	logic [WordW-1:0] rot_val;

	// Crazy-op digit unit
	logic [WordW-1:0] qa, qm, cz_term, cz_sum;
	logic [3:0]       da, dm;
	logic [6:0]       cz_idx;
	logic             cz_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_ok   = is_printable(WordW'(data_char));

	assign rd_word = rd_oob_q ? '0 : ram_rdata;

	// Decode index: (word - 33 + C) mod 94
	assign dec_sum = 17'(rd_word) - 17'(CharLow) + 17'(code_q);
	assign q94     = prod_q[33:23];
	assign dec_idx = 7'(sum_q - 17'(17'(q94) * 17'(TableLen)));
	assign rot_val = rotate_word(md_q);

	// One base-9 digit per cycle
	assign qa      = div9(ca_q);
	assign qm      = div9(cm_q);
	assign da      = 4'(ca_q - WordW'(qa * WordW'(Radix)));
	assign dm      = 4'(cm_q - WordW'(qm * WordW'(Radix)));
	assign cz_idx  = 7'(7'(dm) * 7'(Radix) + 7'(da));
	assign cz_term = WordW'(CrazyTab[cz_idx]) * WordW'(Pow9[ck_q]);
	assign cz_sum  = WordW'(cr_q + cz_term);
	assign cz_last = (ck_q == 3'(CrazyDigits - 1));

	assign mem_raddr = (state_q == ST_DEC) ? data_q : code_q;

	// Select the single memory write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = load_count_q;
		mem_wdata = cz_sum;
		unique case (state_q)
			ST_IDLE: begin
				mem_we    = accept && (phase_q == PhLoading) && (command == CmdLoad) && load_ok;
				mem_wdata = WordW'(data_char);
			end
			ST_FILL: begin
				mem_we = cz_last;
			end
			ST_EXE: begin
				mem_we    = (ins_q == InsRotate);
				mem_waddr = data_q;
				mem_wdata = rot_val;
			end
			ST_CRZ: begin
				mem_we    = cz_last;
				mem_waddr = data_q;
			end
			ST_WB: begin
				mem_we    = is_printable(rd_word);
				mem_waddr = code_q;
				mem_wdata = WordW'(encrypt_char(7'(rd_word - WordW'(CharLow))));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign ram_we = mem_we && (mem_waddr < AddrW'(MemWords));

	tevm_ram #(
		.Width(WordW),
		.Depth(MemWords)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PhLoading;
			acc_q        <= '0;
			code_q       <= '0;
			data_q       <= '0;
			load_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
						if (phase_q == PhLoading) begin
							if (command == CmdLoad && load_ok) begin
								load_count_q <= AddrW'(load_count_q + AddrW'(1));
								if (load_count_q == AddrW'(MemLast)) begin
									phase_q <= PhFailed;
								end
							end else if (command == CmdFinish && load_count_q >= AddrW'(2)) begin
								state_q <= ST_FILL;
							end
						end else if (phase_q == PhRunning && command == CmdStep) begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_FILL: begin
					if (cz_last) begin
						if (load_count_q == AddrW'(MemLast)) begin
							phase_q <= PhRunning;
							state_q <= ST_RESP;
						end else begin
							load_count_q <= AddrW'(load_count_q + AddrW'(1));
						end
					end
				end
				ST_DEC: begin
					if (is_printable(rd_word)) begin
						state_q <= ST_OP;
					end else begin
						code_q  <= wrap_inc(code_q);
						data_q  <= wrap_inc(data_q);
						state_q <= ST_RESP;
					end
				end
				ST_OP: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_ENC;
					unique case (ins_q)
						InsJump:   code_q <= md_q;
						InsMoveD:  data_q <= md_q;
						InsRotate: acc_q  <= rot_val;
						InsCrazy:  state_q <= ST_CRZ;
						InsIn:     acc_q  <= eof_q ? WordW'(MemLast) : WordW'(ch_q);
						InsHalt: begin
							phase_q <= PhHalted;
							state_q <= ST_RESP;
						end
						default: begin
							acc_q <= acc_q;
						end
					endcase
				end
				ST_CRZ: begin
					if (cz_last) begin
						acc_q   <= cz_sum;
						state_q <= ST_ENC;
					end
				end
				ST_ENC: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					code_q  <= wrap_inc(code_q);
					data_q  <= wrap_inc(data_q);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: operands, crazy-op digits, event and result hold
	always_ff @(posedge clk) begin
		rd_oob_q <= (mem_raddr >= AddrW'(MemWords));

		if (accept) begin
			ch_q  <= data_char;
			eof_q <= input_eof;
			oc_q  <= '0;
			ev_q  <= EvNone;
			if (phase_q == PhFailed) begin
				ev_q <= EvLong;
			end else if (phase_q == PhHalted) begin
				ev_q <= EvHalt;
			end else if (phase_q == PhLoading) begin
				if (command == CmdLoad && load_ok && load_count_q == AddrW'(MemLast)) begin
					ev_q <= EvLong;
				end else if (command == CmdFinish && load_count_q < AddrW'(2)) begin
					ev_q <= EvShort;
				end
			end
			// Track the last two loaded words for the fill
			if (phase_q == PhLoading && command == CmdLoad && load_ok) begin
				w2_q <= w1_q;
				w1_q <= WordW'(data_char);
			end
			ca_q <= w1_q;
			cm_q <= w2_q;
			cr_q <= '0;
			ck_q <= '0;
		end

		if (state_q == ST_DEC) begin
			sum_q  <= dec_sum;
			prod_q <= 34'(dec_sum) * 34'(RecipTable);
		end

		if (state_q == ST_OP) begin
			md_q  <= rd_word;
			ins_q <= decode_char(dec_idx);
		end

		if (state_q == ST_EXE) begin
			ca_q <= acc_q;
			cm_q <= md_q;
			cr_q <= '0;
			ck_q <= '0;
			if (ins_q == InsOut) begin
				ev_q <= EvOut;
				oc_q <= acc_q[7:0];
			end else if (ins_q == InsIn) begin
				ev_q <= EvIn;
			end else if (ins_q == InsHalt) begin
				ev_q <= EvHalt;
			end
		end

		// Advance a digit, or start the next fill word
		if (state_q == ST_FILL || state_q == ST_CRZ) begin
			if (state_q == ST_FILL && cz_last) begin
				w2_q <= w1_q;
				w1_q <= cz_sum;
				ca_q <= cz_sum;
				cm_q <= w1_q;
				cr_q <= '0;
				ck_q <= '0;
			end else begin
				ca_q <= qa;
				cm_q <= qm;
				cr_q <= cz_sum;
				ck_q <= 3'(ck_q + 3'd1);
			end
		end

		if (state_q == ST_RESP && slot_free) begin
			out_ev_q   <= ev_q;
			out_oc_q   <= oc_q;
			out_acc_q  <= acc_q;
			out_code_q <= code_q;
			out_data_q <= data_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_ev_q;
	assign out_char     = out_oc_q;
	assign accumulator  = out_acc_q;
	assign code_pointer = out_code_q;
	assign data_pointer = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/tevm_ram.sv @@
// ----------------------------------------------------------------------------
// tevm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tevm_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 1024,
	localparam int unsigned AddrBits = $clog2(Depth)
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AddrBits-1:0] waddr,
	input  wire logic [Width-1:0]    wdata,
	input  wire logic [AddrBits-1:0] raddr,
	output logic      [Width-1:0]    rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: ternary VM core, load / fill / step check
// Loads a generated source text mixed with ignored characters, runs the
// memory fill, and then single-steps the machine until it halts. Both
// handshakes stall at random. A model of the machine kept in the bench
// predicts each untyped result, and each result is compared field by field.
// ----------------------------------------------------------------------------

module testbench;
	import tevm_pkg::*;

	// Spare command code: never decoded, so the block must ignore it
	localparam logic [1:0] CmdSpare = 2'd3;
	// Marker for "any character that decodes to no instruction"
	localparam logic [7:0] NopMark = 8'h00;
	// Source layout: random body up to ProgEnd, then one jump, then halts
	localparam int unsigned ProgEnd = 800;
	localparam int unsigned HaltRun = 8;
	localparam int unsigned StepBudget = 1000;
	localparam int unsigned RunRow = 10;
	localparam int unsigned PlanRows = 23;

	localparam logic [8*TableLen-1:0] OP_WHEEL = {
		"+b(29e*j1VMEKLyC})8&m#~W>qxdRp0wkrUo[D7,XTcA\"lI",
		".v%{gJh4G\\-=O@5`_3i<?Z';FNQuY]szf$!BS/|t:Pn6^Ha"
	};
	localparam logic [8*TableLen-1:0] SCRAMBLE_WHEEL = {
		"5z]&gqtyfr$(we4{WP)H-Zn,[%\\3dL+Q;>U!pJS72FhOA1C",
		"B6v^=I_0/8|jsb9m<.TVac`uY*MK'X~xDl}REokN:#?G\"i@"
	};
	// Digit table indexed [memory digit * 9 + accumulator digit]
	localparam bit [3:0] TRIT_MIX [81] = '{
		4,3,3,1,0,0,1,0,0, 4,3,5,1,0,2,1,0,2, 5,5,4,2,2,1,2,2,1,
		4,3,3,1,0,0,7,6,6, 4,3,5,1,0,2,7,6,8, 5,5,4,2,2,1,8,8,7,
		7,6,6,7,6,6,4,3,3, 7,6,8,7,6,8,4,3,5, 8,8,7,8,8,7,5,5,4
	};
	// Instructions placed right after the two directed source characters
	localparam logic [8*7-1:0] OPENING_OPS = {
		InsRotate, InsCrazy, InsOut, InsIn, InsIn, InsIn, InsOut
	};

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       eof;
	} vm_item_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  oc;
		logic [15:0] acc;
		logic [15:0] cp;
		logic [15:0] dp;
	} vm_result_t;

	typedef struct packed {
		vm_item_t   item;
		logic       typed;
		logic [2:0] ev;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  data_char;
	logic        input_eof;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  event_res;
	logic [7:0]  out_char;
	logic [15:0] accumulator;
	logic [15:0] code_pointer;
	logic [15:0] data_pointer;

	// Machine state as the bench sees it
	logic [15:0] vm_mem [MemWords];
	logic [15:0] vm_acc;
	logic [15:0] vm_cp;
	logic [15:0] vm_dp;
	int unsigned vm_loaded;
	logic [1:0]  vm_phase;

	vm_result_t  pending_results [$];
	logic [7:0]  source_text [$];
	plan_row_t   plan [PlanRows];
	int unsigned mismatch_count = 0;
	int unsigned send_calm = 0;
	int unsigned recv_calm = 0;

	ternary_esoteric_vm_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.data_char    (data_char),
		.input_eof    (input_eof),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.out_char     (out_char),
		.accumulator  (accumulator),
		.code_pointer (code_pointer),
		.data_pointer (data_pointer)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] wheel_char(input logic [8*TableLen-1:0] wheel,
		input int unsigned idx);
		return wheel[(TableLen - 1 - idx) * 8 +: 8];
	endfunction

	function automatic bit in_charset(input logic [15:0] v);
		return (v >= 16'(CharLow)) && (v <= 16'(CharHigh));
	endfunction

	function automatic bit is_opcode(input logic [7:0] c);
		return c == InsJump || c == InsMoveD || c == InsRotate || c == InsCrazy ||
			c == InsOut || c == InsIn || c == InsHalt;
	endfunction

	function automatic logic [15:0] next_addr(input logic [15:0] v);
		return (v == 16'(MemLast)) ? 16'd0 : 16'(v + 16'd1);
	endfunction

	// Combine two words digit by digit in base 9
	function automatic logic [15:0] digit_mix(input logic [15:0] a, input logic [15:0] m);
		int unsigned x, y, w, r, k;
		x = 32'(a);
		y = 32'(m);
		w = 1;
		r = 0;
		for (k = 0; k < CrazyDigits; k++) begin
			r += TRIT_MIX[(y % Radix) * Radix + x % Radix] * w;
			x /= Radix;
			y /= Radix;
			w *= Radix;
		end
		return 16'(r);
	endfunction

	// Source character that decodes to op when stored at address pos
	function automatic logic [7:0] source_char(input logic [7:0] op, input int unsigned pos);
		int unsigned k;
		if (op == NopMark) begin
			do
				k = $urandom_range(0, TableLen - 1);
			while (is_opcode(wheel_char(OP_WHEEL, k)));
		end else begin
			k = 0;
			while (wheel_char(OP_WHEEL, k) != op)
				k++;
		end
		return 8'(CharLow + (k + TableLen - pos % TableLen) % TableLen);
	endfunction

	// Idle cycles before the next transfer; quiet stretches draw no idling
	function automatic int unsigned draw_gap(inout int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 18);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatch_count++;
		end
	endfunction

	// Apply one item to the bench copy of the machine and return its result
	task automatic vm_execute(input vm_item_t it, output vm_result_t res);
		logic [15:0] code_word;
		logic [15:0] data_word;
		logic [7:0]  op;
		logic [2:0]  ev;
		logic [7:0]  oc;
		bit          stop;
		int unsigned addr;
		ev = EvNone;
		oc = '0;
		stop = 1'b0;
		case (vm_phase)
			PhFailed: ev = EvLong;
			PhHalted: ev = EvHalt;
			PhLoading: begin
				if (it.cmd == CmdLoad) begin
					if (in_charset({8'h00, it.ch})) begin
						vm_mem[vm_loaded] = {8'h00, it.ch};
						vm_loaded++;
						if (vm_loaded >= MemWords) begin
							vm_phase = PhFailed;
							ev = EvLong;
						end
					end
				end else if (it.cmd == CmdFinish) begin
					if (vm_loaded < 2) begin
						ev = EvShort;
					end else begin
						for (addr = vm_loaded; addr < MemWords; addr++)
							vm_mem[addr] = digit_mix(vm_mem[addr - 1], vm_mem[addr - 2]);
						vm_phase = PhRunning;
					end
				end
			end
			default: begin
				if (it.cmd == CmdStep) begin
					code_word = vm_mem[vm_cp];
					// Unprintable code words run nothing; pointers still advance
					if (in_charset(code_word)) begin
						data_word = vm_mem[vm_dp];
						op = wheel_char(OP_WHEEL, (code_word - CharLow + vm_cp) % TableLen);
						case (op)
							InsMoveD: vm_dp = data_word;
							InsJump: vm_cp = data_word;
							InsRotate: begin
								data_word = 16'(data_word / 3 + (data_word % 3) * RotWeight);
								vm_mem[vm_dp] = data_word;
								vm_acc = data_word;
							end
							InsCrazy: begin
								data_word = digit_mix(vm_acc, data_word);
								vm_mem[vm_dp] = data_word;
								vm_acc = data_word;
							end
							InsOut: begin
								oc = vm_acc[7:0];
								ev = EvOut;
							end
							InsIn: begin
								vm_acc = it.eof ? 16'(MemLast) : {8'h00, it.ch};
								ev = EvIn;
							end
							InsHalt: begin
								vm_phase = PhHalted;
								ev = EvHalt;
								stop = 1'b1;
							end
							default: ;
						endcase
						// Re-encrypt the word now at C, if printable
						if (!stop) begin
							code_word = vm_mem[vm_cp];
							if (in_charset(code_word))
								vm_mem[vm_cp] = {8'h00,
									wheel_char(SCRAMBLE_WHEEL, code_word - CharLow)};
						end
					end
					if (!stop) begin
						vm_cp = next_addr(vm_cp);
						vm_dp = next_addr(vm_dp);
					end
				end
			end
		endcase
		res = {ev, oc, vm_acc, vm_cp, vm_dp};
	endtask

	// Drive one item, wait for its transfer, and queue the expected result
	task automatic send_item(input vm_item_t it, input bit typed, input logic [2:0] typed_ev);
		int unsigned gap;
		vm_result_t  got;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= it.cmd;
		data_char <= it.ch;
		input_eof <= it.eof;
		do
			@(posedge clk);
		while (!in_ready);
		vm_execute(it, got);
		if (typed)
			got = {typed_ev, 8'h00, 16'h0000, 16'h0000, 16'h0000};
		pending_results.push_back(got);
	endtask

	// Stimulus
	initial begin
		vm_item_t    it;
		int unsigned pos;
		int unsigned row;
		int unsigned steps;
		int unsigned roll;
		logic [7:0]  op;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CmdLoad;
		data_char <= '0;
		input_eof <= 1'b0;
		vm_acc    = '0;
		vm_cp     = '0;
		vm_dp     = '0;
		vm_loaded = 0;
		vm_phase  = PhLoading;

		// Rows flagged typed carry their result; A, C and D stay zero in all of them
		plan = '{
			{CmdStep,   8'hFF,  1'b1, 1'b1, EvNone},
			{CmdFinish, 8'h00,  1'b0, 1'b1, EvShort},
			{CmdSpare,  8'h00,  1'b0, 1'b1, EvNone},
			{CmdLoad,   8'h00,  1'b0, 1'b1, EvNone},
			{CmdLoad,   8'd32,  1'b1, 1'b1, EvNone},
			{CmdLoad,   8'd127, 1'b0, 1'b1, EvNone},
			{CmdLoad,   8'hFF,  1'b0, 1'b1, EvNone},
			{CmdLoad,   8'd33,  1'b0, 1'b1, EvNone},
			{CmdFinish, 8'hFF,  1'b1, 1'b1, EvShort},
			{CmdLoad,   8'd126, 1'b1, 1'b1, EvNone},
			{CmdFinish, 8'h00,  1'b0, 1'b1, EvNone},
			{CmdLoad,   8'd65,  1'b0, 1'b1, EvNone},
			{CmdFinish, 8'h00,  1'b0, 1'b1, EvNone},
			{CmdSpare,  8'hFF,  1'b1, 1'b1, EvNone},
			{CmdStep,   8'h00,  1'b0, 1'b0, EvNone},
			{CmdStep,   8'hFF,  1'b1, 1'b0, EvNone},
			{CmdStep,   8'h5A,  1'b0, 1'b0, EvNone},
			{CmdStep,   8'hA5,  1'b1, 1'b0, EvNone},
			{CmdStep,   8'h00,  1'b0, 1'b0, EvNone},
			{CmdStep,   8'hFF,  1'b0, 1'b0, EvNone},
			{CmdStep,   8'h00,  1'b0, 1'b0, EvNone},
			{CmdStep,   8'h4D,  1'b1, 1'b0, EvNone},
			{CmdStep,   8'h80,  1'b0, 1'b0, EvNone}
		};

		// Build the source from address 2 on; the plan loads addresses 0 and 1.
		// Moves of D start past the printable range so D stays behind C at first.
		// A source that fills memory would leave nothing to run after the single
		// reset, so the overflow path is not driven.
		for (pos = 2; pos <= ProgEnd + HaltRun; pos++) begin
			if (pos < 9) begin
				op = OPENING_OPS[(8 - pos) * 8 +: 8];
			end else if (pos == ProgEnd) begin
				op = InsJump;
			end else if (pos > ProgEnd) begin
				op = InsHalt;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 30)
					op = NopMark;
				else if (roll < 45)
					op = InsRotate;
				else if (roll < 60)
					op = InsCrazy;
				else if (roll < 72)
					op = InsOut;
				else if (roll < 84)
					op = InsIn;
				else
					op = (pos > CharHigh) ? InsMoveD : NopMark;
			end
			source_text.push_back(source_char(op, pos));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < PlanRows; row++) begin
			// Load the source, with ignored items mixed in, before the fill
			if (row == RunRow) begin
				foreach (source_text[i]) begin
					while ($urandom_range(0, 24) == 0) begin
						it.eof = 1'($urandom_range(0, 1));
						roll = $urandom_range(0, 161);
						it.ch = 8'((roll < CharLow) ? roll : roll + TableLen);
						case ($urandom_range(0, 2))
							0: it.cmd = CmdLoad;
							1: it.cmd = CmdStep;
							default: it.cmd = CmdSpare;
						endcase
						send_item(it, 1'b0, EvNone);
					end
					it.cmd = CmdLoad;
					it.ch = source_text[i];
					it.eof = 1'($urandom_range(0, 1));
					send_item(it, 1'b0, EvNone);
				end
			end
			send_item(plan[row].item, plan[row].typed, plan[row].ev);
		end

		// Step until halted, with occasional ignored commands
		steps = 0;
		while (vm_phase != PhHalted && steps < StepBudget) begin
			it.ch = 8'($urandom_range(0, 255));
			it.eof = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 19) == 0) begin
				it.cmd = 2'($urandom_range(0, 3));
				if (it.cmd == CmdStep)
					it.cmd = CmdSpare;
			end else begin
				it.cmd = CmdStep;
				steps++;
			end
			send_item(it, 1'b0, EvNone);
		end

		// Anything after a halt must leave the machine untouched
		repeat (30) begin
			it.cmd = 2'($urandom_range(0, 3));
			it.ch = 8'($urandom_range(0, 255));
			it.eof = 1'($urandom_range(0, 1));
			send_item(it, 1'b0, EvNone);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: stall at random and compare each transfer
	initial begin
		int unsigned gap;
		vm_result_t  want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if (pending_results.size() == 0) begin
				$error("result with no expectation: event %0d", event_res);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("event_res", 16'(want.ev), 16'(event_res));
				check_field("out_char", 16'(want.oc), 16'(out_char));
				check_field("accumulator", want.acc, accumulator);
				check_field("code_pointer", want.cp, code_pointer);
				check_field("data_pointer", want.dp, data_pointer);
			end
		end
	end

	// Hang guard: the fill alone visits every word past the loaded source
	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tevm_pkg.sv
rtl/core/tevm_ram.sv
rtl/core/ternary_esoteric_vm_core.sv
tb/testbench.sv
